FILE: rtl/core/chacha_pkg.sv
// Shared types and constants for the reduced-round ChaCha block core.
// Holds the sequencer control word, the program table and the lane word bundle.
// No dependencies.
`timescale 1ns / 1ps

package chacha_pkg;

  localparam int unsigned MAX_ROUNDS = 20;
  localparam int unsigned ROUNDS_W   = 5;
  localparam int unsigned WORD_W     = 32;
  localparam int unsigned FIELD_W    = 64;
  localparam int unsigned NWORDS     = 16;
  localparam int unsigned NFIELDS    = 8;

  localparam logic [ROUNDS_W-1:0] MAX_ROUNDS_V  = ROUNDS_W'(MAX_ROUNDS);
  localparam logic [ROUNDS_W-1:0] RESET_ROUNDS  =
    (MAX_ROUNDS < 20) ? ROUNDS_W'(MAX_ROUNDS) : ROUNDS_W'(20);

  // Rotation amounts of the quarter round, in the order they are applied.
  localparam int unsigned ROT_1 = 16;
  localparam int unsigned ROT_2 = 12;
  localparam int unsigned ROT_3 = 8;
  localparam int unsigned ROT_4 = 7;

  typedef logic [1:0] pc_t;

  localparam pc_t PC_LOAD   = 2'd0;
  localparam pc_t PC_COLUMN = 2'd1;
  localparam pc_t PC_DIAG   = 2'd2;
  localparam pc_t PC_FINAL  = 2'd3;

  typedef enum logic [1:0] {
    OP_LOAD,
    OP_COLUMN,
    OP_DIAG,
    OP_FINAL
  } op_t;

  // One microcode word: the datapath operation, the step taken when the
  // remaining round count is nonzero, and the step taken when it is zero.
  typedef struct packed {
    op_t op;
    pc_t next_pc;
    pc_t zero_pc;
  } ctrl_t;

  typedef struct packed {
    logic [WORD_W-1:0] a;
    logic [WORD_W-1:0] b;
    logic [WORD_W-1:0] c;
    logic [WORD_W-1:0] d;
  } qr_words_t;

  function automatic ctrl_t program_word(input pc_t pc);
    ctrl_t w;
    case (pc)
      PC_LOAD:   w = '{op: OP_LOAD,   next_pc: PC_COLUMN, zero_pc: PC_FINAL};
      PC_COLUMN: w = '{op: OP_COLUMN, next_pc: PC_DIAG,   zero_pc: PC_FINAL};
      PC_DIAG:   w = '{op: OP_DIAG,   next_pc: PC_COLUMN, zero_pc: PC_FINAL};
      PC_FINAL:  w = '{op: OP_FINAL,  next_pc: PC_LOAD,   zero_pc: PC_LOAD};
      default:   w = '{op: OP_LOAD,   next_pc: PC_LOAD,   zero_pc: PC_LOAD};
    endcase
    return w;
  endfunction

endpackage

FILE: rtl/core/chacha_ifs.sv
// Channel interfaces of the ChaCha block core: input items, result items and
// the round count write channel. Depends on chacha_pkg.
`timescale 1ns / 1ps

interface chacha_in_if;
  logic                             valid;
  logic                             ready;
  logic [chacha_pkg::FIELD_W-1:0]   in_words_0_1;
  logic [chacha_pkg::FIELD_W-1:0]   in_words_2_3;
  logic [chacha_pkg::FIELD_W-1:0]   in_words_4_5;
  logic [chacha_pkg::FIELD_W-1:0]   in_words_6_7;
  logic [chacha_pkg::FIELD_W-1:0]   in_words_8_9;
  logic [chacha_pkg::FIELD_W-1:0]   in_words_10_11;
  logic [chacha_pkg::FIELD_W-1:0]   in_words_12_13;
  logic [chacha_pkg::FIELD_W-1:0]   in_words_14_15;

  modport source (output valid, in_words_0_1, in_words_2_3, in_words_4_5, in_words_6_7,
                  in_words_8_9, in_words_10_11, in_words_12_13, in_words_14_15,
                  input ready);
  modport sink (input valid, in_words_0_1, in_words_2_3, in_words_4_5, in_words_6_7,
                in_words_8_9, in_words_10_11, in_words_12_13, in_words_14_15,
                output ready);
endinterface

interface chacha_out_if;
  logic                             valid;
  logic                             ready;
  logic [chacha_pkg::FIELD_W-1:0]   out_words_0_1;
  logic [chacha_pkg::FIELD_W-1:0]   out_words_2_3;
  logic [chacha_pkg::FIELD_W-1:0]   out_words_4_5;
  logic [chacha_pkg::FIELD_W-1:0]   out_words_6_7;
  logic [chacha_pkg::FIELD_W-1:0]   out_words_8_9;
  logic [chacha_pkg::FIELD_W-1:0]   out_words_10_11;
  logic [chacha_pkg::FIELD_W-1:0]   out_words_12_13;
  logic [chacha_pkg::FIELD_W-1:0]   out_words_14_15;

  modport source (output valid, out_words_0_1, out_words_2_3, out_words_4_5,
                  out_words_6_7, out_words_8_9, out_words_10_11, out_words_12_13,
                  out_words_14_15, input ready);
  modport sink (input valid, out_words_0_1, out_words_2_3, out_words_4_5,
                out_words_6_7, out_words_8_9, out_words_10_11, out_words_12_13,
                out_words_14_15, output ready);
endinterface

interface chacha_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [chacha_pkg::ROUNDS_W-1:0]   round_count;

  modport source (output valid, round_count, input ready);
  modport sink (input valid, round_count, output ready);
endinterface

FILE: rtl/core/chacha_qr.sv
// One ChaCha quarter-round lane: four add, xor and rotate steps on 32-bit words.
// Depends on chacha_pkg for the word bundle and rotation amounts.
`timescale 1ns / 1ps

module chacha_qr (
  input  chacha_pkg::qr_words_t words,
  output chacha_pkg::qr_words_t result
);

  function automatic logic [chacha_pkg::WORD_W-1:0] rotl(
    input logic [chacha_pkg::WORD_W-1:0] v,
    input int unsigned                   s
  );
    return (v << s) | (v >> (chacha_pkg::WORD_W - s));
  endfunction

  logic [chacha_pkg::WORD_W-1:0] a1, d1, c1, b1, a2, d2, c2, b2;

  always_comb begin
    a1 = words.a + words.b;
    d1 = rotl(words.d ^ a1, chacha_pkg::ROT_1);
    c1 = words.c + d1;
    b1 = rotl(words.b ^ c1, chacha_pkg::ROT_2);
    a2 = a1 + b1;
    d2 = rotl(d1 ^ a2, chacha_pkg::ROT_3);
    c2 = c1 + d2;
    b2 = rotl(b1 ^ c2, chacha_pkg::ROT_4);
    result = '{a: a2, b: b2, c: c2, d: d2};
  end

endmodule

FILE: rtl/core/chacha_reduced_round_block_core.sv
// Top level of the reduced-round ChaCha block core: microcode sequencer,
// state registers, four quarter-round lanes and the result register.
// Depends on chacha_pkg, chacha_ifs and chacha_qr.
`timescale 1ns / 1ps

// How to use this block:
// An item on in_ch is one 512-bit ChaCha state, sixteen 32-bit words packed
// two to a field with the even word in the low half. It is accepted at a
// rising edge where in_ch.valid and in_ch.ready are both high. The block
// applies round_count rounds, column and diagonal rounds alternating and
// starting with a column round, adds the input words back in, and presents
// one result item on out_ch, held until out_ch.ready is seen high.
// A small microcode program sequences the work. Its step counter walks a
// load step, then one step per round, then a final add step. Four
// quarter-round lanes work on a whole round together in each round step.
// The block takes no new item until the final add step of the previous item
// is done and the sequencer is back on the load step.
// The result sits in its own register, so the next item is accepted while a
// finished result still waits. If the receiver stalls, the final add step
// holds until the result register is free, and no further item is accepted.
// cfg_ch writes round_count at any time it is always ready; values above 20
// are stored as 20. Writes must only happen while the block is idle.
// Synchronous reset returns the sequencer to the load step, drops out_ch.valid
// and sets round_count to 20.
module chacha_reduced_round_block_core (
  input  logic                clk,
  input  logic                rst,
  chacha_in_if.sink           in_ch,
  chacha_out_if.source        out_ch,
  chacha_cfg_if.sink          cfg_ch
);

  localparam int unsigned W  = chacha_pkg::WORD_W;
  localparam int unsigned RW = chacha_pkg::ROUNDS_W;

  chacha_pkg::pc_t   pc, pc_next;
  chacha_pkg::ctrl_t ctrl;

  logic [RW-1:0] round_count;
  logic [RW-1:0] cnt, cnt_next;
  logic          out_valid;

  logic [W-1:0]                  w      [chacha_pkg::NWORDS];
  logic [W-1:0]                  orig   [chacha_pkg::NWORDS];
  logic [W-1:0]                  round_w[chacha_pkg::NWORDS];
  logic [chacha_pkg::FIELD_W-1:0] in_flat [chacha_pkg::NFIELDS];
  logic [chacha_pkg::FIELD_W-1:0] out_data[chacha_pkg::NFIELDS];

  chacha_pkg::qr_words_t lane_in [4];
  chacha_pkg::qr_words_t lane_out[4];

  logic in_acc, final_go, diag_sel;

  assign ctrl = chacha_pkg::program_word(pc);

  // The input channel is open only on the load step.
  assign in_ch.ready = (ctrl.op == chacha_pkg::OP_LOAD);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  // The final add waits while an earlier result is still unclaimed.
  assign final_go = (ctrl.op == chacha_pkg::OP_FINAL) && (!out_valid || out_ch.ready);

  always_comb begin
    case (ctrl.op)
      chacha_pkg::OP_LOAD:   cnt_next = in_acc ? round_count : cnt;
      chacha_pkg::OP_COLUMN: cnt_next = cnt - RW'(1);
      chacha_pkg::OP_DIAG:   cnt_next = cnt - RW'(1);
      default:               cnt_next = cnt;
    endcase
  end

  always_comb begin
    if ((ctrl.op == chacha_pkg::OP_LOAD && !in_acc) ||
        (ctrl.op == chacha_pkg::OP_FINAL && !final_go)) begin
      pc_next = pc;
    end else if (cnt_next == '0) begin
      pc_next = ctrl.zero_pc;
    end else begin
      pc_next = ctrl.next_pc;
    end
  end

  // Lane i of a column round works on words i, 4+i, 8+i, 12+i. A diagonal
  // round shifts the lower three rows by one, two and three columns.
  assign diag_sel = (ctrl.op == chacha_pkg::OP_DIAG);

  always_comb begin
    logic [1:0] cb, cc, cd;
    for (int i = 0; i < 4; i++) begin
      cb = 2'(i) + (diag_sel ? 2'd1 : 2'd0);
      cc = 2'(i) + (diag_sel ? 2'd2 : 2'd0);
      cd = 2'(i) + (diag_sel ? 2'd3 : 2'd0);
      lane_in[i] = '{a: w[{2'b00, 2'(i)}], b: w[{2'b01, cb}],
                     c: w[{2'b10, cc}],    d: w[{2'b11, cd}]};
    end
  end

  always_comb begin
    logic [1:0] cb, cc, cd;
    round_w = w;
    for (int i = 0; i < 4; i++) begin
      cb = 2'(i) + (diag_sel ? 2'd1 : 2'd0);
      cc = 2'(i) + (diag_sel ? 2'd2 : 2'd0);
      cd = 2'(i) + (diag_sel ? 2'd3 : 2'd0);
      round_w[{2'b00, 2'(i)}] = lane_out[i].a;
      round_w[{2'b01, cb}]    = lane_out[i].b;
      round_w[{2'b10, cc}]    = lane_out[i].c;
      round_w[{2'b11, cd}]    = lane_out[i].d;
    end
  end

  for (genvar g = 0; g < 4; g++) begin : g_lane
    chacha_qr u_qr (
      .words  (lane_in[g]),
      .result (lane_out[g])
    );
  end

  assign in_flat[0] = in_ch.in_words_0_1;
  assign in_flat[1] = in_ch.in_words_2_3;
  assign in_flat[2] = in_ch.in_words_4_5;
  assign in_flat[3] = in_ch.in_words_6_7;
  assign in_flat[4] = in_ch.in_words_8_9;
  assign in_flat[5] = in_ch.in_words_10_11;
  assign in_flat[6] = in_ch.in_words_12_13;
  assign in_flat[7] = in_ch.in_words_14_15;

  // Working state and saved input: loaded on acceptance, updated each round.
  for (genvar k = 0; k < chacha_pkg::NWORDS; k++) begin : g_word
    always_ff @(posedge clk) begin
      if (in_acc) begin
        w[k]    <= in_flat[k / 2][(k % 2) * W +: W];
        orig[k] <= in_flat[k / 2][(k % 2) * W +: W];
      end else if (ctrl.op == chacha_pkg::OP_COLUMN || ctrl.op == chacha_pkg::OP_DIAG) begin
        w[k] <= round_w[k];
      end
    end
  end

  // Result register: feed-forward add of the input words.
  for (genvar f = 0; f < chacha_pkg::NFIELDS; f++) begin : g_field
    always_ff @(posedge clk) begin
      if (final_go) begin
        out_data[f] <= {w[2 * f + 1] + orig[2 * f + 1], w[2 * f] + orig[2 * f]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc          <= chacha_pkg::PC_LOAD;
      cnt         <= '0;
      out_valid   <= 1'b0;
      round_count <= chacha_pkg::RESET_ROUNDS;
    end else begin
      pc  <= pc_next;
      cnt <= cnt_next;
      if (final_go) begin
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
      if (cfg_ch.valid && cfg_ch.ready) begin
        round_count <= (cfg_ch.round_count > chacha_pkg::MAX_ROUNDS_V) ?
                       chacha_pkg::MAX_ROUNDS_V : cfg_ch.round_count;
      end
    end
  end

  assign out_ch.valid           = out_valid;
  assign out_ch.out_words_0_1   = out_data[0];
  assign out_ch.out_words_2_3   = out_data[1];
  assign out_ch.out_words_4_5   = out_data[2];
  assign out_ch.out_words_6_7   = out_data[3];
  assign out_ch.out_words_8_9   = out_data[4];
  assign out_ch.out_words_10_11 = out_data[5];
  assign out_ch.out_words_12_13 = out_data[6];
  assign out_ch.out_words_14_15 = out_data[7];

  // Once an item is taken, the input stays closed until its final add.
  a_no_double_accept: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> !in_ch.ready)
    else $error("input accepted again right after an accept");

  // A result only appears out of the final add step.
  a_result_from_final: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(pc) == chacha_pkg::PC_FINAL)
    else $error("result register loaded outside the final step");

  // The round counter never exceeds the largest legal count.
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= chacha_pkg::MAX_ROUNDS_V && round_count <= chacha_pkg::MAX_ROUNDS_V)
    else $error("round count out of range");

  // A round step always leaves one fewer round to go.
  a_round_count_down: assert property (@(posedge clk) disable iff (rst)
    (ctrl.op == chacha_pkg::OP_COLUMN || ctrl.op == chacha_pkg::OP_DIAG)
      |=> cnt == $past(cnt) - RW'(1))
    else $error("round counter did not step down");

endmodule
